// ===== rtl/core/agf_pkg.sv =====
// shared types and constants of the address gap finder
`default_nettype none
package agf_pkg;
    localparam int ADDR_W = 32;
    localparam int CNT_W = 6;
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_GAP  = 2'd0;
    localparam logic [ST_W-1:0] ST_DONE = 2'd1;
    localparam logic [ST_W-1:0] ST_OVER = 2'd2;
    localparam logic [ST_W-1:0] ST_ERR  = 2'd3;
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_size;
        logic              kind;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] gap_start;
        logic [ADDR_W-1:0] gap_size;
        logic [CNT_W-1:0]  gap_total;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        index;
        logic [ADDR_W-1:0] data;
    } cfg_item_t;

    // controller to datapath
    typedef struct packed {
        logic store_wr;      // load one region
        logic sort_init;     // begin sort: j index and pass count reset
        logic sort_rd;       // read entries j, j+1
        logic sort_wb;       // compare-exchange write back
        logic sweep_init;    // cursor to base, index 0
        logic sweep_rd;      // read entry at sweep index
        logic sweep_eval;    // evaluate one region
        logic final_eval;    // evaluate final gap
        logic clr_count;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       win_zero;
        logic       sort_end;   // all passes done
        logic       sweep_end;  // index past count
        logic       gap_due;
        logic       at_limit;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/agf_if.sv =====
// valid/ready channel interfaces
`default_nettype none
interface agf_in_if;
    import agf_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface agf_out_if;
    import agf_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface agf_cfg_if;
    import agf_pkg::*;
    logic      valid;
    logic      ready;
    cfg_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/agf_datapath.sv =====
// region store, bubble sort over memory and sweep cursor
`default_nettype none
module agf_datapath #(
    parameter int MAX_REGIONS = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire agf_pkg::dp_cmd_t        cmd,
    input  wire logic [31:0]             ld_start,
    input  wire logic [31:0]             ld_size,
    input  wire logic [31:0]             window_base,
    input  wire logic [31:0]             window_size,
    input  wire logic [5:0]              gap_limit,
    input  wire logic [5:0]              count,
    output agf_pkg::dp_stat_t            stat,
    output logic [31:0]                  gap_start,
    output logic [31:0]                  gap_size
);
    import agf_pkg::*;
    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);

    // bank a takes port 1 writes and bank b port 2 writes, so two entries write at once
    logic [63:0] mem_a [MAX_REGIONS];
    logic [63:0] mem_b [MAX_REGIONS];
    logic [63:0] rd_a_reg, rd_b_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] pass_reg, pass_next;
    logic [31:0] cursor_reg, cursor_next;
    logic [IW-1:0] wr_addr;
    logic [63:0] wr_data;
    logic wr_en, wr2_en;
    logic [IW-1:0] wr2_addr;
    logic [63:0] wr2_data;
    logic [31:0] win_end, rs, re;
    logic swap, in_win;

    assign win_end = window_base + window_size;
    assign rs = rd_a_reg[63:32];
    assign re = rd_a_reg[63:32] + rd_a_reg[31:0];
    assign in_win = (rs >= window_base) && (rs < win_end);
    assign swap = rd_a_reg[63:32] > rd_b_reg[63:32];

    // a swap writes entries j and j+1 in the same cycle, j+1 through port 2
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = n_reg[IW-1:0];
        wr_data = {ld_start, ld_size};
        wr2_en = 1'b0;
        wr2_addr = j_reg[IW-1:0] + IW'(1);
        wr2_data = rd_a_reg;
        if (cmd.store_wr && (n_reg < CW'(MAX_REGIONS)))
        begin
            wr_en = 1'b1;
        end
        else if (cmd.sort_wb && swap)
        begin
            wr_en = 1'b1;
            wr_addr = j_reg[IW-1:0];
            wr_data = rd_b_reg;
            wr2_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr2_en)
        begin
            mem_b[wr2_addr] <= wr2_data;
        end
    end

    // c and d copy a and b so that entry j+1 has read ports of its own
    logic [63:0] mem_c [MAX_REGIONS];
    logic [63:0] mem_d [MAX_REGIONS];
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_c[wr_addr] <= wr_data;
        end
        if (wr2_en)
        begin
            mem_d[wr2_addr] <= wr2_data;
        end
    end

    // per entry: latest copy sits in b/d rather than a/c
    logic [MAX_REGIONS-1:0] in_b_reg;
    logic [IW-1:0] ra_addr, rb_addr;
    always_comb
    begin
        ra_addr = j_reg[IW-1:0];
        rb_addr = j_reg[IW-1:0] + IW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_rd || cmd.sweep_rd)
        begin
            rd_a_reg <= in_b_reg[ra_addr] ? mem_b[ra_addr] : mem_a[ra_addr];
            rd_b_reg <= in_b_reg[rb_addr] ? mem_d[rb_addr] : mem_c[rb_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_b_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                in_b_reg[wr_addr] <= 1'b0;
            end
            if (wr2_en)
            begin
                in_b_reg[wr2_addr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        j_next = j_reg;
        pass_next = pass_reg;
        cursor_next = cursor_reg;
        if (cmd.sort_init)
        begin
            j_next = '0;
            pass_next = '0;
        end
        else if (cmd.sort_wb)
        begin
            if (j_reg + CW'(2) >= n_reg - pass_reg)
            begin
                j_next = '0;
                pass_next = pass_reg + CW'(1);
            end
            else
            begin
                j_next = j_reg + CW'(1);
            end
        end
        else if (cmd.sweep_init)
        begin
            j_next = '0;
            cursor_next = window_base;
        end
        else if (cmd.sweep_eval)
        begin
            j_next = j_reg + CW'(1);
            if (in_win && re > cursor_reg && !(rs > cursor_reg && count >= gap_limit))
            begin
                cursor_next = re;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            j_reg <= '0;
            pass_reg <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            j_reg <= j_next;
            pass_reg <= pass_next;
            cursor_reg <= cursor_next;
            if (cmd.clr_count)
            begin
                n_reg <= '0;
            end
            else if (wr_en && cmd.store_wr)
            begin
                n_reg <= n_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        stat.win_zero = (window_size == '0);
        stat.sort_end = (n_reg < CW'(2)) || (pass_reg + CW'(1) >= n_reg);
        stat.sweep_end = (j_reg >= n_reg);
        stat.at_limit = (count >= gap_limit);
        if (cmd.final_eval)
        begin
            stat.gap_due = cursor_reg < win_end;
            gap_start = cursor_reg;
            gap_size = win_end - cursor_reg;
        end
        else
        begin
            stat.gap_due = in_win && (rs > cursor_reg);
            gap_start = cursor_reg;
            gap_size = rs - cursor_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/agf_control.sv =====
// sequencer for load, sort, sweep and result hand-off
`default_nettype none
module agf_control (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_kind,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output agf_pkg::out_item_t        out_data,
    output agf_pkg::dp_cmd_t          cmd,
    input  wire agf_pkg::dp_stat_t    stat,
    input  wire logic [31:0]          gap_start,
    input  wire logic [31:0]          gap_size,
    output logic [5:0]                count
);
    import agf_pkg::*;
    typedef enum logic [2:0] {
        S_IDLE, S_SRD, S_SWB, S_WRD, S_WEV, S_FIN, S_OUT
    } state_t;
    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic [5:0] count_reg, count_next;

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign count = count_reg;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next = out_reg;
        count_next = count_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (!in_kind)
                    begin
                        cmd.store_wr = 1'b1;
                    end
                    else
                    begin
                        count_next = '0;
                        if (stat.win_zero)
                        begin
                            cmd.clr_count = 1'b1;
                            out_valid_next = 1'b1;
                            out_next = '{ST_ERR, 32'd0, 32'd0, 6'd0, 1'b1};
                        end
                        else
                        begin
                            cmd.sort_init = 1'b1;
                            state_next = S_SRD;
                        end
                    end
                end
            end
            S_SRD:
            begin
                if (stat.sort_end)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next = S_WRD;
                end
                else
                begin
                    cmd.sort_rd = 1'b1;
                    state_next = S_SWB;
                end
            end
            S_SWB:
            begin
                cmd.sort_wb = 1'b1;
                state_next = S_SRD;
            end
            S_WRD:
            begin
                if (stat.sweep_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.sweep_rd = 1'b1;
                    state_next = S_WEV;
                end
            end
            S_WEV:
            begin
                if (!out_valid_reg)
                begin
                    cmd.sweep_eval = 1'b1;
                    state_next = S_WRD;
                    if (stat.gap_due)
                    begin
                        out_valid_next = 1'b1;
                        if (stat.at_limit)
                        begin
                            out_next = '{ST_OVER, 32'd0, 32'd0, count_reg, 1'b1};
                            cmd.clr_count = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            count_next = count_reg + 6'd1;
                            out_next = '{ST_GAP, gap_start, gap_size, count_reg + 6'd1,
                                         1'b0};
                        end
                    end
                end
            end
            S_FIN:
            begin
                cmd.final_eval = 1'b1;
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    if (stat.gap_due && stat.at_limit)
                    begin
                        out_next = '{ST_OVER, 32'd0, 32'd0, count_reg, 1'b1};
                        cmd.clr_count = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (stat.gap_due)
                    begin
                        count_next = count_reg + 6'd1;
                        out_next = '{ST_GAP, gap_start, gap_size, count_reg + 6'd1, 1'b0};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        out_next = '{ST_DONE, 32'd0, 32'd0, count_reg, 1'b1};
                        cmd.clr_count = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{ST_DONE, 32'd0, 32'd0, count_reg, 1'b1};
                    cmd.clr_count = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end
endmodule
`default_nettype wire

// ===== rtl/core/address_gap_finder_unit.sv =====
// address gap finder top level
// load: a transaction gives no result; loads can follow back to back while no result is pending
// run over n regions: a bubble sort that reads, then writes back, each pair,
// then a sweep that reads and evaluates each region and a final gap check, plus output stalls
// results leave one at a time from a register; input waits until the run ends
// reset clears the region count, registers to window 0/0 and limit 63
`default_nettype none
module address_gap_finder_unit #(
    parameter int MAX_REGIONS = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    agf_in_if.sink   in_ch,
    agf_out_if.source out_ch,
    agf_cfg_if.sink  cfg
);
    import agf_pkg::*;
    logic [31:0] base_reg, size_reg;
    logic [5:0] limit_reg;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [31:0] gs, gz;
    logic [5:0] count;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            size_reg <= '0;
            limit_reg <= 6'd63;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_BASE:  base_reg <= cfg.data.data;
                REG_SIZE:  size_reg <= cfg.data.data;
                REG_LIMIT: limit_reg <= cfg.data.data[5:0];
                default:   ;
            endcase
        end
    end

    agf_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .ld_start(in_ch.data.region_start), .ld_size(in_ch.data.region_size),
        .window_base(base_reg), .window_size(size_reg), .gap_limit(limit_reg),
        .count(count), .stat(stat), .gap_start(gs), .gap_size(gz)
    );

    agf_control u_ctl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_kind(in_ch.data.kind), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cmd(cmd), .stat(stat), .gap_start(gs), .gap_size(gz), .count(count)
    );
endmodule
`default_nettype wire

// ===== rtl/core/agf_checker.sv =====
// port-level checks of the gap finder
`default_nettype none
module agf_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [1:0] status,
    input wire logic last,
    input wire logic [5:0] gap_total
);
    import agf_pkg::*;
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (status != ST_GAP))) else $error("last mismatch");
    a_gap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_GAP) |-> (gap_total != 6'd0)) else $error("gap count");
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)))
        else $error("result dropped");
endmodule

bind address_gap_finder_unit agf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.data.status),
    .last(out_ch.data.last), .gap_total(out_ch.data.gap_total)
);
`default_nettype wire
